// ----- rtl/pfr_pkg.sv -----
// Shared types and constants for the powerline frame receiver.
// No dependencies; imported by every module of the block.
package pfr_pkg;

  localparam int FRAME_BITS = 14;
  localparam int PAT_W      = 14;
  localparam int IDX_W      = 2;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 3;
  localparam int DATA_W     = 8;

  localparam logic [CNT_W-1:0] GAP_ZEROS = 3'd6;

  localparam logic [PAT_W-1:0] ADDR_RESET = 14'd14405;
  localparam logic [PAT_W-1:0] CMD1_RESET = 14'd14406;
  localparam logic [PAT_W-1:0] CMD2_RESET = 14'd14410;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ADDR = 2'd0;
  localparam logic [IDX_W-1:0] REG_CMD1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_CMD2 = 2'd2;

  // command codes (chosen and executed)
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_TOGGLE = 2'd1;
  localparam logic [1:0] CMD_OTHER  = 2'd2;

  // field masks, first received bit in bit 13
  localparam logic [PAT_W-1:0] MASK_START = 14'h3C00;
  localparam logic [PAT_W-1:0] MASK_HOUSE = 14'h03C0;
  localparam logic [PAT_W-1:0] MASK_UNIT  = 14'h003C;
  localparam logic [PAT_W-1:0] MASK_SUFX  = 14'h0003;

  // one result word; light_state sits in bit 0
  typedef struct packed {
    logic [CNT_W-1:0] frames_matched;
    logic [1:0]       executed_command;
    logic             other_flag;
    logic             light_state;
  } pfr_result_t;

endpackage

// ----- rtl/powerline_frame_receiver_top.sv -----
// Powerline frame receiver: one line bit per word in, one status word out.
// The status word is registered: output valid rises in the cycle after an input word is accepted (result register).
// Throughput: 1 word per cycle while the sink takes each output word; the sequence state updates in one pass per bit.
// Reset (rst, synchronous): sequence state cleared, patterns back to defaults,
// output register empty. Depends on pfr_pkg, pfr_core, pfr_out_stage.
module powerline_frame_receiver_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [pfr_pkg::DATA_W-1:0]  s_axis_tdata,  // [0] line_bit
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] light_state, [1] other_flag, [3:2] executed_command, [6:4] frames_matched
  output logic [pfr_pkg::DATA_W-1:0]  m_axis_tdata,
  input  logic                        cfg_wr_en,
  input  logic [pfr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pfr_pkg::PAT_W-1:0]   cfg_data
);
  import pfr_pkg::*;

  logic        accept;
  pfr_result_t result;
  pfr_result_t out_data;

  assign accept = s_axis_tvalid && s_axis_tready;

  pfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .line_bit  (s_axis_tdata[0]),
    .result    (result)
  );

  pfr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .ready  (s_axis_tready),
    .valid  (m_axis_tvalid),
    .take   (m_axis_tready),
    .data   (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data};

endmodule

// ----- rtl/pfr_core.sv -----
// Receiver sequence state, configuration registers and per-bit update logic.
// Depends on pfr_pkg.
module pfr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pfr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pfr_pkg::PAT_W-1:0]  cfg_data,
  input  logic                       accept,
  input  logic                       line_bit,
  output pfr_pkg::pfr_result_t       result
);
  import pfr_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] bit_position;
    logic             frame_active;
    logic             start_ok;
    logic             house_ok;
    logic             unit_ok;
    logic [CNT_W-1:0] frame_count;
    logic [1:0]       chosen_command;
    logic [CNT_W-1:0] gap_zeros;
    logic             gap_done;
    logic             gap_counting;
    logic             light_reg;
    logic             other_reg;
  } seq_t;

  logic [PAT_W-1:0] address_pattern;
  logic [PAT_W-1:0] command_one_pattern;
  logic [PAT_W-1:0] command_two_pattern;
  logic [PAT_W-1:0] frame_store;
  logic [PAT_W-1:0] frame_store_next;
  seq_t             seq;
  seq_t             seq_next;
  logic [1:0]       done;

  function automatic seq_t restart(input seq_t s);
    seq_t r;
    r = '0;
    r.light_reg = s.light_reg;
    r.other_reg = s.other_reg;
    return r;
  endfunction

  function automatic logic field_match(input logic [PAT_W-1:0] st,
                                       input logic [PAT_W-1:0] pat,
                                       input logic [PAT_W-1:0] mask);
    return ((st ^ pat) & mask) == '0;
  endfunction

  always_comb begin
    seq_t             s;
    logic [PAT_W-1:0] st;
    logic [POS_W-1:0] idx;
    s    = seq;
    st   = frame_store;
    done = CMD_NONE;
    idx  = POS_W'(FRAME_BITS - 1) - seq.bit_position;

    if (line_bit && s.bit_position == '0) begin
      s.frame_active = 1'b1;
    end else if (s.frame_count == 3'd2 && !s.gap_done) begin
      s.gap_counting = 1'b1;
      s.gap_zeros    = s.gap_zeros + 3'd1;
      if (s.gap_zeros == GAP_ZEROS) begin
        s.gap_done     = 1'b1;
        s.gap_counting = 1'b0;
      end
    end

    if (s.frame_active) begin
      if (s.gap_counting) begin
        s = restart(s);
      end else begin
        if (s.bit_position < POS_W'(FRAME_BITS)) begin
          st[idx] = line_bit;
        end
        s.bit_position = s.bit_position + 4'd1;

        // address fields
        if (s.bit_position == 4'd4) begin
          if (field_match(st, address_pattern, MASK_START)) s.start_ok = 1'b1;
          else s = restart(s);
        end else if (s.start_ok && s.bit_position == 4'd8) begin
          if (field_match(st, address_pattern, MASK_HOUSE)) s.house_ok = 1'b1;
          else s = restart(s);
        end else if (s.house_ok && s.bit_position == 4'd12 && s.frame_count < 3'd2) begin
          if (field_match(st, address_pattern, MASK_UNIT)) s.unit_ok = 1'b1;
          else s = restart(s);
        end else if (s.unit_ok && s.bit_position == 4'd14 && s.frame_count < 3'd2) begin
          if (field_match(st, address_pattern, MASK_SUFX)) s.frame_count = s.frame_count + 3'd1;
          else s = restart(s);
        end

        // command fields
        if (s.gap_done && s.frame_count >= 3'd2) begin
          if (s.house_ok && s.bit_position == 4'd12 &&
              (s.frame_count == 3'd2 || s.frame_count == 3'd3)) begin
            if (field_match(st, command_one_pattern, MASK_UNIT)) begin
              if (s.chosen_command == CMD_NONE || s.chosen_command == CMD_TOGGLE)
                s.chosen_command = CMD_TOGGLE;
            end else if (field_match(st, command_two_pattern, MASK_UNIT)) begin
              if (s.chosen_command == CMD_NONE || s.chosen_command == CMD_OTHER)
                s.chosen_command = CMD_OTHER;
            end else begin
              s = restart(s);
            end
          end
          if (s.bit_position == 4'd14) begin
            if (field_match(st, command_one_pattern, MASK_SUFX))
              s.frame_count = s.frame_count + 3'd1;
            else s = restart(s);
          end
          if (s.frame_count == 3'd4) begin
            if (s.chosen_command == CMD_TOGGLE) begin
              if (!s.light_reg) begin
                s.light_reg = 1'b1;
              end else begin
                s.light_reg = 1'b0;
                s.other_reg = 1'b0;
              end
              done = CMD_TOGGLE;
            end else if (s.chosen_command == CMD_OTHER) begin
              s.other_reg = 1'b1;
              done = CMD_OTHER;
            end
            s = restart(s);
          end
        end

        if (s.bit_position >= POS_W'(FRAME_BITS)) begin
          s.bit_position = '0;
          s.frame_active = 1'b0;
        end
      end
    end

    seq_next         = s;
    frame_store_next = st;
  end

  assign result.light_state      = seq_next.light_reg;
  assign result.other_flag       = seq_next.other_reg;
  assign result.executed_command = done;
  assign result.frames_matched   = seq_next.frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq                 <= '0;
      address_pattern     <= ADDR_RESET;
      command_one_pattern <= CMD1_RESET;
      command_two_pattern <= CMD2_RESET;
    end else begin
      if (accept) seq <= seq_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ADDR: address_pattern     <= cfg_data;
          REG_CMD1: command_one_pattern <= cfg_data;
          REG_CMD2: command_two_pattern <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) frame_store <= frame_store_next;
  end

endmodule

// ----- rtl/pfr_out_stage.sv -----
// Output register holding one result word until the sink takes it.
// Depends on pfr_pkg.
module pfr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pfr_pkg::pfr_result_t result,
  output logic                 ready,
  output logic                 valid,
  input  logic                 take,
  output pfr_pkg::pfr_result_t data
);
  import pfr_pkg::*;

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= result;
  end

endmodule
